@@ rtl/assert_macros.svh @@
// Assertion macros shared by the noise burst voice RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define NBEV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies a condition in the next.
`define NBEV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NBEV_ASSERT(lbl, prop, msg)
`define NBEV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/nbev_pkg.sv @@
// Shared types, constants and helpers for the noise burst voice.
package nbev_pkg;

  localparam int SAMPLE_BITS  = 24;
  localparam int RELEASE_BITS = 16;
  localparam int CMD_BITS     = 2;
  localparam int LEVEL_BITS   = 7;
  localparam int Q24_BITS     = 24;
  localparam int GAIN_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 26;
  localparam int PROD_W = 2 * MUL_W;

  // shared divider: dividend holds the release step numerator, envelope plus half length
  localparam int DIV_W     = Q24_BITS + 1;
  localparam int DVSR_W    = RELEASE_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int VOICE_SHIFT = 48 - SAMPLE_BITS;

  localparam logic [CMD_BITS-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_TRIG = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REL  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LPF   = 2'd2;

  localparam logic [31:0]           NOISE_SEED  = 32'h2545F491;
  localparam logic [Q24_BITS-1:0]   ENV_FULL    = 24'hFFFFFF;
  localparam logic [Q24_BITS-1:0]   ENV_FLOOR   = 24'd16777;
  localparam logic [LEVEL_BITS-1:0] LEVEL_RESET = 7'd100;
  localparam logic [Q24_BITS-1:0]   DECAY_RESET = 24'd16773000;

  // gain = (percent * 393216 + 500) / 1000 = percent * 393 + (54 * percent + 125) / 250;
  // the last division is a reciprocal product, exact for every 7-bit percent
  localparam int GAIN_NUM_W     = 13;
  localparam int GAIN_PROD_W    = 27;
  localparam int GAIN_RCP_SHIFT = 21;
  localparam logic [GAIN_BITS-1:0]   GAIN_INT      = 16'd393;
  localparam logic [GAIN_NUM_W-1:0]  GAIN_FRAC_MUL = 13'd54;
  localparam logic [GAIN_NUM_W-1:0]  GAIN_FRAC_ADD = 13'd125;
  localparam logic [GAIN_PROD_W-1:0] GAIN_RCP      = 27'd8389;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FILT_A,
    S_FILT_B,
    S_FILT_C,
    S_GAIN,
    S_GAIN_W,
    S_VOICE,
    S_VOICE_W,
    S_DECAY,
    S_DECAY_W,
    S_DONE
  } nbev_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] w);
    logic [31:0] x;
    x = w ^ (w << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

@@ rtl/nbev_mul.sv @@
// Shared signed multiplier with a registered product.
module nbev_mul (
  input  logic                               clk,
  input  logic signed [nbev_pkg::MUL_W-1:0]  a,
  input  logic signed [nbev_pkg::MUL_W-1:0]  b,
  output logic signed [nbev_pkg::PROD_W-1:0] prod_r
);
  import nbev_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

@@ rtl/nbev_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module nbev_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [nbev_pkg::DIV_W-1:0]        dividend,
  input  logic [nbev_pkg::DVSR_W-1:0]       divisor,
  output nbev_pkg::div_stat_t               stat,
  output logic [nbev_pkg::DIV_W-1:0]        quotient
);
  import nbev_pkg::*;

  `include "assert_macros.svh"

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DVSR_W-1:0]    rem_r;
  logic [DVSR_W-1:0]    dvsr_r;

  logic [DVSR_W:0]      rem_sh;
  logic [DVSR_W:0]      diff;
  logic                 take;
  logic [DVSR_W-1:0]    rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    diff    = rem_sh - {1'b0, dvsr_r};
    take    = ~diff[DVSR_W];
    rem_nxt = take ? diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_W-2:0], take};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `NBEV_ASSERT(a_div_excl, !(stat.done && stat.busy), "divider done while still busy")
  `NBEV_ASSERT_NEXT(a_div_start, start, stat.busy, "divider not busy after start")
  `NBEV_ASSERT(a_div_done, stat.done |-> $past(stat.busy), "divider done without a run")

endmodule

@@ rtl/noise_burst_envelope_voice_top.sv @@
// Top level of the noise burst voice: ports, sequencer and datapath state.
//
// Noise burst voice. A trigger word (tuser 1) reseeds the xorshift32 noise source,
// clears the one-pole lowpass, latches the gain from level_percent and raises the
// envelope to full scale. A sample tick word (tuser 0) adds lowpassed noise times
// gain times envelope onto in_sample with 24-bit saturation, then decays the
// envelope geometrically, or linearly once a quick release word (tuser 2) has set
// a per-sample step of envelope / release_samples. The voice stops once the
// envelope reaches -60 dB. Every input word yields exactly one output word.
// A pass-through word or a trigger goes straight to the done state (the gain
// comes from level_percent through a constant reciprocal product); a sounding
// tick runs five products (four in quick release) through the one registered
// 26x26 multiplier, each with an issue and a capture state, the two lowpass
// products overlapping; a release start on a sounding voice waits for the 25-step
// shared divider that forms the release step. in_tready is high only while the
// sequencer is idle; a finished word waits in the output register, so the next
// word is taken while the previous result is still unclaimed. Configuration
// writes (cfg_index 0 level_percent, 1 env_decay_mult, 2 lowpass_coeff) are
// always taken and belong between items.
module noise_burst_envelope_voice_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input words
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] release_samples, [39:16] in_sample
  input  logic [39:0]                           in_tdata,
  // [1:0] command
  input  logic [nbev_pkg::CMD_BITS-1:0]         in_tuser,
  // result words
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [23:0] out_sample
  output logic [23:0]                           out_tdata,
  // [0] voice_active
  output logic [0:0]                            out_tuser,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [nbev_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [nbev_pkg::Q24_BITS-1:0]         cfg_data
);
  import nbev_pkg::*;

  `include "assert_macros.svh"

  localparam int SB = SAMPLE_BITS;
  localparam int RB = RELEASE_BITS;

  localparam logic signed [PROD_W-1:0] RND_Q24   = PROD_W'(2**23);
  localparam logic signed [PROD_W-1:0] RND_Q16   = PROD_W'(2**15);
  localparam logic signed [PROD_W-1:0] RND_VOICE = PROD_W'(2**(VOICE_SHIFT-1));
  localparam logic signed [PROD_W-1:0] FILT_MAX  = PROD_W'(2**23 - 1);
  localparam logic signed [PROD_W-1:0] FILT_MIN  = -PROD_W'(2**23);
  localparam logic signed [SB+1:0]     SMAX_EXT  = $signed({3'b000, {(SB-1){1'b1}}});
  localparam logic signed [SB+1:0]     SMIN_EXT  = $signed({3'b111, {(SB-1){1'b0}}});
  localparam logic [Q24_BITS:0]        ONE_Q24   = 25'h1000000;

  // configuration
  logic [LEVEL_BITS-1:0] level_r;
  logic [Q24_BITS-1:0]   decay_r;
  logic [Q24_BITS-1:0]   lpf_r;

  // voice state
  logic [31:0]                noise_r;
  logic signed [Q24_BITS-1:0] filt_r;
  logic [Q24_BITS-1:0]        env_r;
  logic [Q24_BITS-1:0]        rdec_r;
  logic [GAIN_BITS-1:0]       gain_r;
  logic                       inrel_r;
  logic                       sound_r;

  // sequencer and working registers
  nbev_state_t              state_r, state_nxt;
  logic signed [SB-1:0]     smp_r;
  logic signed [SB-1:0]     res_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [Q24_BITS:0] t_r;

  // output register
  logic                 out_tvalid_r;
  logic signed [SB-1:0] out_smp_r;
  logic                 out_act_r;

  // input decode
  logic [CMD_BITS-1:0]  in_cmd;
  logic [RB-1:0]        in_rel;
  logic signed [SB-1:0] in_smp;
  logic                 in_fire;
  logic                 run_tick;
  logic                 do_div;
  logic [RB-1:0]        rel_n;
  logic [DIV_W-1:0]     rel_num;
  logic [GAIN_NUM_W-1:0]  gain_num;
  logic [GAIN_PROD_W-1:0] gain_prod;
  logic [GAIN_BITS-1:0]   gain_calc;

  // shared units
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;
  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [DVSR_W-1:0]        div_divisor;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_quo;

  // datapath after the multiplier
  logic signed [Q24_BITS-1:0] noise_s;
  logic signed [PROD_W-1:0]   filt_sum;
  logic signed [PROD_W-1:0]   filt_rnd;
  logic signed [Q24_BITS-1:0] filt_sat;
  logic signed [PROD_W-1:0]   t_full;
  logic signed [PROD_W-1:0]   voice_full;
  logic signed [SB+1:0]       sum_ext;
  logic signed [SB-1:0]       sum_sat;
  logic [PROD_W-1:0]          env_full;
  logic [Q24_BITS-1:0]        env_dec;
  logic                       out_load;

  assign in_cmd  = in_tuser;
  assign in_rel  = in_tdata[RB-1:0];
  assign in_smp  = $signed(in_tdata[RB+SB-1:RB]);
  assign in_fire = in_tvalid & in_tready;

  assign run_tick = (in_cmd == CMD_TICK) && sound_r && (env_r > ENV_FLOOR);
  assign do_div   = (in_cmd == CMD_REL) && sound_r;

  // zero release length counts as one sample
  assign rel_n    = (in_rel == '0) ? RB'(1) : in_rel;
  assign rel_num  = DIV_W'(env_r) + DIV_W'(rel_n >> 1);

  // trigger gain: integer part by shift-add, rounded fraction by reciprocal product
  assign gain_num  = GAIN_NUM_W'(level_r) * GAIN_FRAC_MUL + GAIN_FRAC_ADD;
  assign gain_prod = GAIN_PROD_W'(gain_num) * GAIN_RCP;
  assign gain_calc = GAIN_BITS'(level_r) * GAIN_INT + GAIN_BITS'(gain_prod >> GAIN_RCP_SHIFT);

  // noise in Q1.23: top 24 bits of the word, offset by half scale
  assign noise_s = $signed({~noise_r[31], noise_r[30:8]});

  always_comb begin
    filt_sum   = acc_r + prod;
    filt_rnd   = (filt_sum + RND_Q24) >>> 24;
    if (filt_rnd > FILT_MAX) begin
      filt_sat = $signed(24'h7FFFFF);
    end else if (filt_rnd < FILT_MIN) begin
      filt_sat = $signed(24'h800000);
    end else begin
      filt_sat = filt_rnd[Q24_BITS-1:0];
    end

    t_full     = (prod + RND_Q16) >>> 16;
    voice_full = (prod + RND_VOICE) >>> VOICE_SHIFT;

    sum_ext = {{2{smp_r[SB-1]}}, smp_r} + voice_full[SB+1:0];
    if (sum_ext > SMAX_EXT) begin
      sum_sat = SMAX_EXT[SB-1:0];
    end else if (sum_ext < SMIN_EXT) begin
      sum_sat = SMIN_EXT[SB-1:0];
    end else begin
      sum_sat = sum_ext[SB-1:0];
    end

    // envelope product is never negative
    env_full = PROD_W'($unsigned(prod + RND_Q24) >> 24);
    env_dec  = (env_full > PROD_W'(ENV_FULL)) ? ENV_FULL : env_full[Q24_BITS-1:0];
  end

  nbev_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  nbev_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (do_div) begin
            state_nxt = S_DIV;
          end else if (run_tick) begin
            state_nxt = S_FILT_A;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_DONE;
        end
      end
      S_FILT_A:  state_nxt = S_FILT_B;
      S_FILT_B:  state_nxt = S_FILT_C;
      S_FILT_C:  state_nxt = S_GAIN;
      S_GAIN:    state_nxt = S_GAIN_W;
      S_GAIN_W:  state_nxt = S_VOICE;
      S_VOICE:   state_nxt = S_VOICE_W;
      S_VOICE_W: state_nxt = inrel_r ? S_DONE : S_DECAY;
      S_DECAY:   state_nxt = S_DECAY_W;
      S_DECAY_W: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs: handshake, divider start and multiplier operands
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    out_load     = (state_r == S_DONE) && (!out_tvalid_r || out_tready);
    div_start    = in_fire && do_div;
    div_dividend = rel_num;
    div_divisor  = DVSR_W'(rel_n);
    mul_a        = '0;
    mul_b        = '0;
    case (state_r)
      S_FILT_A: begin
        mul_a = $signed({2'b00, lpf_r});
        mul_b = {{2{filt_r[Q24_BITS-1]}}, filt_r};
      end
      S_FILT_B: begin
        mul_a = $signed({1'b0, ONE_Q24 - {1'b0, lpf_r}});
        mul_b = {{2{noise_s[Q24_BITS-1]}}, noise_s};
      end
      S_GAIN: begin
        mul_a = $signed({{(MUL_W-GAIN_BITS){1'b0}}, gain_r});
        mul_b = {{2{filt_r[Q24_BITS-1]}}, filt_r};
      end
      S_VOICE: begin
        mul_a = {t_r[Q24_BITS], t_r};
        mul_b = $signed({2'b00, env_r});
      end
      S_DECAY: begin
        mul_a = $signed({2'b00, env_r});
        mul_b = $signed({2'b00, decay_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // configuration, voice state and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      level_r <= LEVEL_RESET;
      decay_r <= DECAY_RESET;
      lpf_r   <= '0;
      noise_r <= NOISE_SEED;
      filt_r  <= '0;
      env_r   <= '0;
      rdec_r  <= '0;
      gain_r  <= '0;
      inrel_r <= 1'b0;
      sound_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          REG_LEVEL: level_r <= cfg_data[LEVEL_BITS-1:0];
          REG_DECAY: decay_r <= cfg_data;
          REG_LPF:   lpf_r   <= cfg_data;
          default:   ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && run_tick) begin
            noise_r <= xorshift32(noise_r);
          end else if (in_fire && (in_cmd == CMD_TRIG)) begin
            // restart the voice; zero gain leaves it silent
            gain_r  <= gain_calc;
            filt_r  <= '0;
            noise_r <= NOISE_SEED;
            inrel_r <= 1'b0;
            rdec_r  <= '0;
            if (gain_calc != '0) begin
              env_r   <= ENV_FULL;
              sound_r <= 1'b1;
            end else begin
              env_r   <= '0;
              sound_r <= 1'b0;
            end
          end else if (in_fire && (in_cmd == CMD_TICK) && sound_r) begin
            // envelope at the floor: stop the voice
            sound_r <= 1'b0;
            inrel_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            // release step is at least one so the release always ends
            rdec_r  <= (div_quo == '0) ? Q24_BITS'(1) : div_quo[Q24_BITS-1:0];
            inrel_r <= 1'b1;
          end
        end
        S_FILT_C: filt_r <= filt_sat;
        S_VOICE_W: begin
          if (inrel_r) begin
            if (env_r <= rdec_r) begin
              env_r   <= '0;
              inrel_r <= 1'b0;
              sound_r <= 1'b0;
            end else begin
              env_r <= env_r - rdec_r;
            end
          end
        end
        S_DECAY_W: env_r <= env_dec;
        default: ;
      endcase
    end
  end

  // working registers of the current word
  always_ff @(posedge clk) begin
    if (in_fire) begin
      smp_r <= in_smp;
      res_r <= in_smp;
    end
    case (state_r)
      S_FILT_B:  acc_r <= prod;
      S_GAIN_W:  t_r   <= t_full[Q24_BITS:0];
      S_VOICE_W: res_r <= sum_sat;
      default:   ;
    endcase
  end

  // output register: hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_smp_r <= res_r;
      out_act_r <= sound_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_smp_r;
  assign out_tuser  = out_act_r;
  assign cfg_ready  = 1'b1;

  `NBEV_ASSERT(a_idle_div_free, in_tready |-> !div_stat.busy, "divider busy while idle")
  `NBEV_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready,
                    "second word taken while one is in work")
  `NBEV_ASSERT(a_release_sounding, !inrel_r || sound_r, "quick release on a silent voice")

endmodule
